// ===== hdl/hexanacci_term_mod_top_assert.svh =====
// ----------------------------------------------------------------------------
// hexanacci_term_mod_top_assert.svh
// Assertion macros used by the top module of the hexanacci term block.
// ----------------------------------------------------------------------------
`ifndef HEXANACCI_TERM_MOD_TOP_ASSERT_SVH
`define HEXANACCI_TERM_MOD_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define HXM_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define HXM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hxm_pkg.sv =====
// ----------------------------------------------------------------------------
// hxm_pkg
// Types, constants and helpers for the order-six recurrence term block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hxm_pkg;

	// Recurrence order and modulus
	localparam int          ORDER   = 6;
	localparam int unsigned MODULUS = 10000007;
	localparam int          VAL_W   = 24;
	localparam int          IDX_W   = $clog2(ORDER);
	localparam int          CNT_W   = 31;

	// Matrix storage: two banks of ORDER x ORDER entries
	localparam int MAT_N     = ORDER * ORDER;
	localparam int RAM_DEPTH = 2 * MAT_N;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	// Barrett reduction constants
	localparam int PROD_W = 2 * VAL_W;
	localparam int MU_W   = VAL_W + 1;
	localparam int RED_W  = VAL_W + 2;
	localparam logic [MU_W-1:0] BARRETT_MU =
		MU_W'((64'd1 << PROD_W) / 64'(MODULUS));

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam val_t MOD_V   = VAL_W'(MODULUS);
	localparam idx_t IDX_MAX = IDX_W'(ORDER - 1);

	// Tag that travels with each multiply-accumulate term
	typedef struct packed {
		logic  sqr;    // matrix square (else vector product)
		logic  first;  // first term of a dot product
		logic  last;   // last term of a dot product
		addr_t dst;    // RAM address, or vector slot in the low bits
	} mac_tag_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_STEP,
		ST_VEC,
		ST_VDRAIN,
		ST_SHIFT,
		ST_SQR,
		ST_SDRAIN
	} hxm_state_t;

	// Row-major matrix entry offset inside one bank
	function automatic addr_t mat_idx(idx_t r, idx_t c);
		return addr_t'(ADDR_W'(r) * ADDR_W'(ORDER) + ADDR_W'(c));
	endfunction

	// Base address of a bank
	function automatic addr_t bank_base(logic bank);
		return bank ? ADDR_W'(MAT_N) : '0;
	endfunction

endpackage

// ===== hdl/hxm_ram.sv =====
// ----------------------------------------------------------------------------
// hxm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hxm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== hdl/hxm_mulmod.sv =====
// ----------------------------------------------------------------------------
// hxm_mulmod
// Pipelined modular multiplier: a * b mod MODULUS by Barrett reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hxm_mulmod import hxm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_vld,
	input  val_t     a,
	input  val_t     b,
	input  mac_tag_t in_tag,
	output logic     out_vld,
	output val_t     r,
	output mac_tag_t out_tag,
	output logic     busy
);

	localparam logic [RED_W-1:0] MOD_R  = RED_W'(MODULUS);
	localparam logic [RED_W-1:0] MOD2_R = RED_W'(2 * MODULUS);

	logic [4:0]           vld_q;
	mac_tag_t             tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [PROD_W-1:0]    p_s2, p_s3, p_s4;
	logic [MU_W-1:0]      q_s3;
	logic [MU_W+VAL_W-1:0] qm_s4;
	logic [RED_W-1:0]     r_s5;
	val_t                 r_s6;
	logic [2*MU_W-1:0]    qest;
	logic [MU_W-1:0]      q1;

	// quotient estimate
	assign q1   = p_s2[PROD_W-1:VAL_W-1];
	assign qest = (2*MU_W)'(q1) * (2*MU_W)'(BARRETT_MU);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_vld};
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		p_s2   <= PROD_W'(a) * PROD_W'(b);
		tag_s2 <= in_tag;
		q_s3   <= qest[2*MU_W-1 -: MU_W];
		p_s3   <= p_s2;
		tag_s3 <= tag_s2;
		qm_s4  <= (MU_W+VAL_W)'(q_s3) * (MU_W+VAL_W)'(MOD_V);
		p_s4   <= p_s3;
		tag_s4 <= tag_s3;
		// remainder is below 3*MODULUS, so the low bits suffice
		r_s5   <= p_s4[RED_W-1:0] - qm_s4[RED_W-1:0];
		tag_s5 <= tag_s4;
		if (r_s5 >= MOD2_R) begin
			r_s6 <= VAL_W'(r_s5 - MOD2_R);
		end else if (r_s5 >= MOD_R) begin
			r_s6 <= VAL_W'(r_s5 - MOD_R);
		end else begin
			r_s6 <= VAL_W'(r_s5);
		end
		tag_s6 <= tag_s5;
	end

	assign out_vld = vld_q[4];
	assign r       = r_s6;
	assign out_tag = tag_s6;
	assign busy    = |vld_q;

endmodule

// ===== hdl/hexanacci_term_mod_top.sv =====
// An index below 6 goes straight to the result; a larger one fills the
//   companion matrix and runs square-and-multiply over the bits of (n - 5).
// The block takes one item at a time: in_ready is high only while idle, and the
//   216 products of each matrix square go through the single multiply-mod pipeline.
// Reset: arst_n clears the sequencer and valid flags; the RAM is not cleared.
// ----------------------------------------------------------------------------
// hexanacci_term_mod_top
// Term n of the order-six additive recurrence modulo 10000007, by
// square-and-multiply of the companion matrix held in a two-bank RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hexanacci_term_mod_top_assert.svh"

module hexanacci_term_mod_top import hxm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [VAL_W-1:0] seed_0,
	input  logic [VAL_W-1:0] seed_1,
	input  logic [VAL_W-1:0] seed_2,
	input  logic [VAL_W-1:0] seed_3,
	input  logic [VAL_W-1:0] seed_4,
	input  logic [VAL_W-1:0] seed_5,
	input  logic [CNT_W-1:0] term_index,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] term_value
);

	hxm_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             bank_q;
	idx_t             i_q, j_q, k_q;
	val_t             vec_q [ORDER];
	val_t             tmp_q [ORDER];
	val_t             acc_q;
	logic             out_valid_q;
	val_t             term_value_q;

	val_t     seeds [ORDER];
	logic     in_xfer;
	logic     issue;
	logic     last_ij;
	logic     pipe_busy;
	logic     rd_valid_s1;
	mac_tag_t tag_s1;
	idx_t     k_s1;
	mac_tag_t iss_tag;
	addr_t    raddr_a, raddr_b;
	val_t     rdata_a, rdata_b;
	val_t     mm_a;
	logic     mm_vld, mm_busy;
	val_t     mm_r;
	mac_tag_t mm_tag;
	logic     ram_we;
	addr_t    ram_waddr;
	val_t     ram_wdata;
	logic [VAL_W:0] acc_sum;
	val_t     acc_next;
	logic     out_load;

	function automatic val_t seed_red(val_t s);
		return (s >= MOD_V) ? val_t'(s - MOD_V) : s;
	endfunction

	assign seeds[0] = seed_0;
	assign seeds[1] = seed_1;
	assign seeds[2] = seed_2;
	assign seeds[3] = seed_3;
	assign seeds[4] = seed_4;
	assign seeds[5] = seed_5;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign pipe_busy = rd_valid_s1 || mm_busy;
	assign issue     = (state_q == ST_VEC) || (state_q == ST_SQR);
	assign last_ij   = (j_q == IDX_MAX) && (k_q == IDX_MAX);
	assign out_load  = (state_q == ST_STEP) && (cnt_q == '0) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (term_index < CNT_W'(ORDER)) ? ST_STEP : ST_INIT;
				end
			end
			ST_INIT: begin
				if ((i_q == IDX_MAX) && (j_q == IDX_MAX)) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (cnt_q == '0) begin
					if (out_load) begin
						state_d = ST_IDLE;
					end
				end else if (cnt_q[0]) begin
					state_d = ST_VEC;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_VEC: begin
				if (last_ij) begin
					state_d = ST_VDRAIN;
				end
			end
			ST_VDRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				state_d = ((cnt_q >> 1) != '0) ? ST_SQR : ST_STEP;
			end
			ST_SQR: begin
				if (last_ij && (i_q == IDX_MAX)) begin
					state_d = ST_SDRAIN;
				end
			end
			ST_SDRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_STEP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer control: counters, exponent, bank select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bank_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					i_q    <= '0;
					j_q    <= '0;
					k_q    <= '0;
					bank_q <= 1'b0;
					if (in_xfer) begin
						cnt_q <= (term_index < CNT_W'(ORDER)) ? '0 :
							term_index - CNT_W'(ORDER - 1);
					end
				end
				ST_INIT: begin
					if (j_q == IDX_MAX) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_STEP: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q >> 1;
					i_q   <= '0;
					j_q   <= '0;
					k_q   <= '0;
				end
				ST_VEC, ST_SQR: begin
					if (k_q == IDX_MAX) begin
						k_q <= '0;
						if (j_q == IDX_MAX) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SDRAIN: begin
					if (!pipe_busy) begin
						bank_q <= ~bank_q;
					end
				end
				default: ;
			endcase
		end
	end

	// issue addresses and tag
	always_comb begin
		raddr_a       = bank_base(bank_q) + mat_idx(i_q, k_q);
		raddr_b       = bank_base(bank_q) + mat_idx(k_q, j_q);
		iss_tag.sqr   = (state_q == ST_SQR);
		iss_tag.first = (k_q == '0);
		iss_tag.last  = (k_q == IDX_MAX);
		iss_tag.dst   = (state_q == ST_SQR) ? bank_base(~bank_q) + mat_idx(i_q, j_q) :
			addr_t'(j_q);
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= iss_tag;
		k_s1   <= k_q;
	end

	assign mm_a = tag_s1.sqr ? rdata_a : vec_q[k_s1];

	hxm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	hxm_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (rd_valid_s1),
		.a       (mm_a),
		.b       (rdata_b),
		.in_tag  (tag_s1),
		.out_vld (mm_vld),
		.r       (mm_r),
		.out_tag (mm_tag),
		.busy    (mm_busy)
	);

	// modular accumulate
	always_comb begin
		acc_sum  = {1'b0, (mm_tag.first ? val_t'(0) : acc_q)} + {1'b0, mm_r};
		acc_next = (acc_sum >= {1'b0, MOD_V}) ? VAL_W'(acc_sum - {1'b0, MOD_V}) :
			VAL_W'(acc_sum);
	end

	// RAM write: companion matrix fill or squared-matrix write-back
	always_comb begin
		if (state_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = mat_idx(i_q, j_q);
			ram_wdata = ((j_q == '0) || (j_q == i_q + 1'b1)) ? val_t'(1) : '0;
		end else begin
			ram_we    = mm_vld && mm_tag.last && mm_tag.sqr;
			ram_waddr = mm_tag.dst;
			ram_wdata = acc_next;
		end
	end

	// vector, accumulator and result payload; a small index parks its seed in slot 0
	always_ff @(posedge clk) begin
		if (mm_vld) begin
			acc_q <= acc_next;
			if (mm_tag.last && !mm_tag.sqr) begin
				tmp_q[mm_tag.dst[IDX_W-1:0]] <= acc_next;
			end
		end
		if (in_xfer) begin
			for (int n = 0; n < ORDER; n++) begin
				if ((n == 0) && (term_index < CNT_W'(ORDER))) begin
					vec_q[n] <= seed_red(seeds[term_index[IDX_W-1:0]]);
				end else begin
					vec_q[n] <= seed_red(seeds[ORDER-1-n]);
				end
			end
		end else if ((state_q == ST_VDRAIN) && !pipe_busy) begin
			vec_q <= tmp_q;
		end
		if (out_load) begin
			term_value_q <= vec_q[0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign term_value = term_value_q;

	`HXM_ASSERT_IMPLIES(a_idle_drained, in_ready, !pipe_busy, "input taken with work in flight")
	`HXM_ASSERT_IMPLIES(a_wb_other_bank, ram_we && (state_q != ST_INIT), (ram_waddr >= addr_t'(MAT_N)) == !bank_q, "write-back hits the bank being read")
	`HXM_ASSERT_IMPLIES(a_mm_range, mm_vld, mm_r < MOD_V, "product not reduced")
	`HXM_ASSERT_IMPLIES(a_out_range, out_valid_q, term_value_q < MOD_V, "result out of range")

endmodule
